// ----- rtl/tld_pkg.sv -----
// Shared types, byte codes and helpers for the telnet line discipline.
package tld_pkg;

  localparam logic [7:0] B_IAC   = 8'hff;
  localparam logic [7:0] B_WILL  = 8'hfb;
  localparam logic [7:0] B_WONT  = 8'hfc;
  localparam logic [7:0] B_DO    = 8'hfd;
  localparam logic [7:0] B_DONT  = 8'hfe;
  localparam logic [7:0] B_CR    = 8'h0d;
  localparam logic [7:0] B_LF    = 8'h0a;
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_DEL   = 8'h7f;
  localparam logic [7:0] B_ETX   = 8'h03;
  localparam logic [7:0] B_SP    = 8'h20;
  localparam logic [7:0] B_TILDE = 8'h7e;
  localparam logic [7:0] B_ZERO  = 8'h00;

  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_STATUS = 8'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_APPEND = 3'd1,
    EV_ERASE  = 3'd2,
    EV_LINE   = 3'd3,
    EV_INTR   = 3'd4,
    EV_CONN   = 3'd5
  } event_t;

  // One reply: up to three bytes, event reported on the final word.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    event_t     ev;
    logic [7:0] ch;
  } job_t;

  function automatic logic refused_option(input logic [7:0] opt);
    return opt inside {8'd24, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd37, 8'd39};
  endfunction

endpackage

// ----- rtl/tld_if.sv -----
// Valid/ready channel interfaces for the input and result words.
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] peer_byte;
  logic       peer_valid;
  logic [2:0] event_res;
  logic [7:0] event_char;
  logic       last;

  modport source (output valid, peer_byte, peer_valid, event_res, event_char, last,
                  input ready);
  modport sink   (input valid, peer_byte, peer_valid, event_res, event_char, last,
                  output ready);
endinterface

// ----- rtl/tld_front.sv -----
// Front end: accepts words, tracks line and command state, builds reply jobs.
module tld_front #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic          clk,
  input  logic          rst,
  tld_in_if.sink        in_ch,
  input  logic          q_ready,
  output logic          q_push,
  output tld_pkg::job_t q_job
);
  import tld_pkg::*;

  localparam logic [7:0] CAP = 8'(LINE_CAPACITY);

  logic [7:0] line_count, line_count_next;
  logic       in_command, in_command_next;
  logic [1:0] command_length, command_length_next;
  logic [7:0] command_verb, command_verb_next;
  logic       accept;
  logic [7:0] b;
  job_t       job;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign b           = in_ch.rx_byte;
  assign q_job       = job;
  assign q_push      = accept && (job.cnt != 2'd0);

  always_comb begin
    line_count_next     = line_count;
    in_command_next     = in_command;
    command_length_next = command_length;
    command_verb_next   = command_verb;
    job                 = '{b0: B_ZERO, b1: B_ZERO, b2: B_ZERO, cnt: 2'd0,
                            ev: EV_NONE, ch: B_ZERO};
    if (in_ch.action) begin
      job = '{b0: B_IAC, b1: B_WILL, b2: OPT_ECHO, cnt: 2'd3, ev: EV_CONN, ch: B_ZERO};
    end else if (in_command || b == B_IAC) begin
      if (b == B_IAC) begin
        in_command_next     = 1'b1;
        command_length_next = 2'd1;
        command_verb_next   = B_ZERO;
      end else if (command_length < 2'd2) begin
        command_verb_next   = b;
        command_length_next = 2'd2;
        if (!(b inside {B_WILL, B_WONT, B_DO, B_DONT})) begin
          in_command_next     = 1'b0;
          command_length_next = 2'd0;
        end
      end else begin
        in_command_next     = 1'b0;
        command_length_next = 2'd0;
        if (command_verb == B_WILL && refused_option(b)) begin
          job = '{b0: B_IAC, b1: B_DONT, b2: b, cnt: 2'd3, ev: EV_NONE, ch: B_ZERO};
        end else if (command_verb == B_DO && b == OPT_SGA) begin
          job = '{b0: B_IAC, b1: B_WILL, b2: b, cnt: 2'd3, ev: EV_NONE, ch: B_ZERO};
        end else if (command_verb == B_DO && b == OPT_STATUS) begin
          job = '{b0: B_IAC, b1: B_WONT, b2: b, cnt: 2'd3, ev: EV_NONE, ch: B_ZERO};
        end
      end
    end else if (b inside {B_CR, B_ETX}) begin
      line_count_next = 8'd0;
      job = '{b0: B_CR, b1: B_LF, b2: B_ZERO, cnt: 2'd2,
              ev: (b == B_CR) ? EV_LINE : EV_INTR, ch: B_ZERO};
    end else if (b inside {B_BS, B_DEL}) begin
      if (line_count != 8'd0) begin
        line_count_next = line_count - 8'd1;
        job = '{b0: B_BS, b1: B_SP, b2: B_BS, cnt: 2'd3, ev: EV_ERASE, ch: B_ZERO};
      end
    end else if (b inside {[B_SP:B_TILDE]}) begin
      if (line_count < CAP) begin
        line_count_next = line_count + 8'd1;
        job = '{b0: b, b1: B_ZERO, b2: B_ZERO, cnt: 2'd1, ev: EV_APPEND, ch: b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= 8'd0;
      in_command     <= 1'b0;
      command_length <= 2'd0;
      command_verb   <= 8'd0;
    end else if (accept) begin
      line_count     <= line_count_next;
      in_command     <= in_command_next;
      command_length <= command_length_next;
      command_verb   <= command_verb_next;
    end
  end

endmodule

// ----- rtl/tld_queue.sv -----
// Short job queue between front and back ends.
module tld_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tld_pkg::job_t wdata,
  output logic          ready,
  output logic          valid,
  input  logic          pop,
  output tld_pkg::job_t rdata
);
  import tld_pkg::*;

  localparam logic [QUEUE_AW:0] FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign ready   = (count != FULL);
  assign valid   = (count != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/tld_back.sv -----
// Back end: plays out each job one word per cycle while the receiver is ready, through an output register.
module tld_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tld_pkg::job_t q_job,
  output logic          q_pop,
  tld_out_if.source     out_ch
);
  import tld_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       o_valid;
  logic [7:0] o_byte;
  event_t     o_ev;
  logic [7:0] o_ch;
  logic       o_last;
  logic       adv;
  logic       emit;
  logic       is_last;
  logic [7:0] sel_byte;

  assign adv     = !o_valid || out_ch.ready;
  assign emit    = busy && adv;
  assign is_last = (idx == cur.cnt - 2'd1);
  assign q_pop   = q_valid && (!busy || (emit && is_last));

  always_comb begin
    case (idx)
      2'd0:    sel_byte = cur.b0;
      2'd1:    sel_byte = cur.b1;
      default: sel_byte = cur.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      idx     <= 2'd0;
      o_valid <= 1'b0;
    end else begin
      if (adv) begin
        o_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (emit) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (emit) begin
      o_byte <= sel_byte;
      o_ev   <= is_last ? cur.ev : EV_NONE;
      o_ch   <= is_last ? cur.ch : B_ZERO;
      o_last <= is_last;
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.peer_byte  = o_byte;
  assign out_ch.peer_valid = 1'b1;
  assign out_ch.event_res  = o_ev;
  assign out_ch.event_char = o_ch;
  assign out_ch.last       = o_last;

endmodule

// ----- rtl/telnet_line_discipline.sv -----
// Telnet receive line discipline with IAC option negotiation (top level).
//
// in_ch carries one received byte (action 0) or a new-connection event
// (action 1) per word. out_ch carries the bytes to send back to the peer,
// one per word, with the host event on the word marked last. A word that
// causes no reply gives no output word.
//
// The front end classifies a word in the cycle it is accepted and pushes a
// reply job into a four-entry queue; the back end plays a job out at one
// word per cycle while the receiver is ready, through an output register.
// The queue, the job register and the output register lie between a word
// and its first reply. Input is taken every cycle while the queue has room,
// so output sets the rate: echo 1 word, CR/Ctrl-C 2, erase and option 3.
//
// Reset clears the line count, the command state, the queue and the output
// register. When the receiver stalls, the output word holds, the queue
// fills, and in_ch.ready drops once four jobs are waiting.
module telnet_line_discipline #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic      clk,
  input  logic      rst,
  tld_in_if.sink    in_ch,
  tld_out_if.source out_ch
);
  import tld_pkg::*;

  logic q_push;
  logic q_ready;
  logic q_valid;
  logic q_pop;
  job_t push_job;
  job_t pop_job;

  tld_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_job  (push_job)
  );

  tld_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(push_job),
    .ready(q_ready),
    .valid(q_valid),
    .pop  (q_pop),
    .rdata(pop_job)
  );

  tld_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_job  (pop_job),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> q_ready)
    else $error("job pushed into full queue");

  a_pop_job: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && pop_job.cnt != 2'd0))
    else $error("empty job taken from queue");

  a_event_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_res != EV_NONE) |-> out_ch.last)
    else $error("event on a word that is not last");

  a_append_char: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_res == EV_APPEND) |->
      (out_ch.event_char == out_ch.peer_byte))
    else $error("appended char differs from echoed byte");

endmodule

// ----- test/tb.sv -----
// Testbench for telnet_line_discipline: directed and random streams against a predictor.
`timescale 1ns / 100ps

module tb;
  import tld_pkg::*;

  localparam int LINE_CAP    = 255;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [7:0] NEG_VERBS [4] = '{B_WILL, B_WONT, B_DO, B_DONT};
  localparam logic [7:0] HOT_OPTS [13] = '{8'd1, 8'd3, 8'd5, 8'd24, 8'd31, 8'd32, 8'd33,
                                           8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39};

  typedef struct packed {
    logic [7:0] peer_byte;
    logic       peer_valid;
    event_t     ev;
    logic [7:0] ch;
    logic       last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tld_in_if  in_ch();
  tld_out_if out_ch();

  telnet_line_discipline #(.LINE_CAPACITY(LINE_CAP)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] line_cnt = '0;
  logic       cmd_on   = 1'b0;
  logic [1:0] cmd_len  = '0;
  logic [7:0] cmd_verb = '0;

  reply_t pending_replies[$];
  reply_t want;

  int errors      = 0;
  int n_sent      = 0;
  int n_connect   = 0;
  int n_checked   = 0;
  int quiet_cnt   = 0;
  int hold_cycles = 0;
  bit sender_idle = 1'b1;
  bit sink_idle   = 1'b1;

  task automatic push_reply(input logic [7:0] pb, input event_t ev, input logic [7:0] ch,
                            input logic fin);
    reply_t r;
    r.peer_byte  = pb;
    r.peer_valid = 1'b1;
    r.ev         = ev;
    r.ch         = ch;
    r.last       = fin;
    pending_replies.push_back(r);
  endtask

  task automatic push_triple(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input event_t ev);
    push_reply(a, EV_NONE, 8'h00, 1'b0);
    push_reply(b, EV_NONE, 8'h00, 1'b0);
    push_reply(c, ev, 8'h00, 1'b1);
  endtask

  task predict_replies(input logic act, input logic [7:0] b);
    if (act) begin
      n_connect++;
      push_triple(B_IAC, B_WILL, OPT_ECHO, EV_CONN);
    end else if (cmd_on || b == B_IAC) begin
      if (b == B_IAC) begin
        cmd_on   = 1'b1;
        cmd_len  = 2'd1;
        cmd_verb = 8'h00;
      end else if (cmd_len < 2'd2) begin
        cmd_verb = b;
        cmd_len  = 2'd2;
        if (!(b inside {B_WILL, B_WONT, B_DO, B_DONT})) begin
          cmd_on  = 1'b0;
          cmd_len = 2'd0;
        end
      end else begin
        cmd_on  = 1'b0;
        cmd_len = 2'd0;
        if (cmd_verb == B_WILL &&
            (b inside {8'd24, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd37, 8'd39}))
          push_triple(B_IAC, B_DONT, b, EV_NONE);
        else if (cmd_verb == B_DO && b == OPT_SGA)
          push_triple(B_IAC, B_WILL, b, EV_NONE);
        else if (cmd_verb == B_DO && b == OPT_STATUS)
          push_triple(B_IAC, B_WONT, b, EV_NONE);
      end
    end else if (b == B_CR || b == B_ETX) begin
      line_cnt = 8'd0;
      push_reply(B_CR, EV_NONE, 8'h00, 1'b0);
      push_reply(B_LF, (b == B_CR) ? EV_LINE : EV_INTR, 8'h00, 1'b1);
    end else if (b == B_BS || b == B_DEL) begin
      if (line_cnt != 8'd0) begin
        line_cnt = line_cnt - 8'd1;
        push_triple(B_BS, B_SP, B_BS, EV_ERASE);
      end
    end else if (b >= B_SP && b <= B_TILDE && line_cnt < LINE_CAP) begin
      line_cnt = line_cnt + 8'd1;
      push_reply(b, EV_APPEND, b, 1'b1);
    end
  endtask

  // input monitor: predict on every accepted word
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      predict_replies(in_ch.action, in_ch.rx_byte);
  end

  // reply checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display({"%0t: unexpected reply word: expected none, ",
                  "got byte %h valid %b ev %0d ch %h last %b"},
                 $time, out_ch.peer_byte, out_ch.peer_valid, out_ch.event_res,
                 out_ch.event_char, out_ch.last);
      end else begin
        want = pending_replies.pop_front();
        n_checked++;
        if (out_ch.peer_byte !== want.peer_byte || out_ch.peer_valid !== want.peer_valid ||
            out_ch.event_res !== want.ev || out_ch.event_char !== want.ch ||
            out_ch.last !== want.last) begin
          errors++;
          $display("%0t: reply mismatch: expected byte %h valid %b ev %0d ch %h last %b",
                   $time, want.peer_byte, want.peer_valid, want.ev, want.ch, want.last);
          $display("%0t:                 got      byte %h valid %b ev %0d ch %h last %b",
                   $time, out_ch.peer_byte, out_ch.peer_valid, out_ch.event_res,
                   out_ch.event_char, out_ch.last);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task send_word(input logic act, input logic [7:0] b);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task send_random_traffic(input int n);
    int cnt;
    int pick;
    int extra;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_word(1'b0, 8'($urandom_range(B_SP, B_TILDE)));
        cnt++;
      end else if (pick < 46) begin
        send_word(1'b0, $urandom_range(0, 1) ? B_CR : B_ETX);
        cnt++;
      end else if (pick < 56) begin
        send_word(1'b0, $urandom_range(0, 1) ? B_BS : B_DEL);
        cnt++;
      end else if (pick < 64) begin
        send_word(1'b0, 8'($urandom_range(0, 254)));
        cnt++;
      end else if (pick < 84) begin
        send_word(1'b0, B_IAC);
        send_word(1'b0, NEG_VERBS[$urandom_range(0, 3)]);
        send_word(1'b0, $urandom_range(0, 1) ? HOT_OPTS[$urandom_range(0, 12)]
                                             : 8'($urandom_range(0, 254)));
        cnt += 3;
      end else if (pick < 88) begin
        send_word(1'b0, B_IAC);
        send_word(1'b0, 8'($urandom_range(0, 250)));
        cnt += 2;
      end else if (pick < 94) begin
        // broken command: may be cut short or restarted by another IAC
        send_word(1'b0, B_IAC);
        extra = $urandom_range(0, 2);
        repeat (extra)
          send_word(1'b0, $urandom_range(0, 3) == 0 ? B_IAC : 8'($urandom_range(0, 255)));
        cnt += 1 + extra;
      end else begin
        send_word(1'b1, 8'($urandom_range(0, 255)));
        cnt++;
      end
    end
  endtask

  task test_connect();
    send_word(1'b1, 8'h5a);
  endtask

  task test_line_editing();
    send_word(1'b0, B_BS);
    send_word(1'b0, B_SP);
    send_word(1'b0, B_TILDE);
    send_word(1'b0, B_DEL);
    send_word(1'b0, B_ZERO);
    send_word(1'b0, 8'h1f);
    send_word(1'b0, 8'h80);
    send_word(1'b0, B_CR);
    send_word(1'b0, B_ETX);
  endtask

  task test_negotiation();
    send_word(1'b0, B_IAC); send_word(1'b0, B_WILL); send_word(1'b0, 8'd24);
    send_word(1'b0, B_IAC); send_word(1'b0, B_DO);   send_word(1'b0, OPT_SGA);
    send_word(1'b0, B_IAC); send_word(1'b0, B_DO);   send_word(1'b0, OPT_STATUS);
    send_word(1'b0, B_IAC); send_word(1'b0, 8'hf1);
    // restart inside an unfinished command
    send_word(1'b0, B_IAC); send_word(1'b0, B_WILL);
    send_word(1'b0, B_IAC); send_word(1'b0, B_DONT); send_word(1'b0, OPT_ECHO);
  endtask

  task test_line_full();
    send_word(1'b0, B_CR);
    repeat (LINE_CAP + 2) send_word(1'b0, 8'($urandom_range(B_SP, B_TILDE)));
    send_word(1'b0, B_BS);
    send_word(1'b0, 8'($urandom_range(B_SP, B_TILDE)));
    send_word(1'b0, 8'($urandom_range(B_SP, B_TILDE)));
  endtask

  task test_random_traffic();
    send_random_traffic(20);
  endtask

  task test_backpressure();
    hold_cycles = 80;
    send_random_traffic(24);
  endtask

  task test_steady_flow();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    send_random_traffic(40);
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.action  <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_connect();
    test_line_editing();
    test_negotiation();
    test_line_full();
    test_random_traffic();
    test_backpressure();
    test_steady_flow();

    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb: %0d words sent, %0d of them connection events; %0d reply words checked",
             n_sent, n_connect, n_checked);
    $display("tb: covered editing up to a full line, option replies, broken commands, long stall");
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tld_pkg.sv
rtl/tld_if.sv
rtl/tld_front.sv
rtl/tld_queue.sv
rtl/tld_back.sv
rtl/telnet_line_discipline.sv
test/tb.sv
